// File: hdl/columnar_transposition_cipher_assert.svh
// Assertion macros shared by the cipher RTL
`ifndef COLUMNAR_TRANSPOSITION_CIPHER_ASSERT_SVH
`define COLUMNAR_TRANSPOSITION_CIPHER_ASSERT_SVH
`ifndef SYNTHESIS
`define CPT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CPT_NEVER(label, clk, rst_n, cond, msg) \
    `CPT_ASSERT(label, clk, rst_n, !(cond), msg)
`else
`define CPT_ASSERT(label, clk, rst_n, prop, msg)
`define CPT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: hdl/cpt_pkg.sv
// Constants and register codes for the columnar transposition cipher
package cpt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int MAX_KEY_DEF  = 8;

    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int KLEN_W    = 4;

    localparam logic [7:0] PAD_CHAR = 8'h58;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_CHARS,
        REG_KEY_LENGTH,
        REG_MODE
    } cfg_reg_t;

endpackage

// File: hdl/cpt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module cpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/columnar_transposition_cipher.sv
// Top level of the columnar transposition cipher
`include "columnar_transposition_cipher_assert.svh"
// Usage:
//   Configure key_chars, key_length and mode through wr_en / wr_index / wr_data
//   while busy is low. Present message bytes on data_byte with start; an item
//   is taken at a clock edge where start is high and busy is low. Bytes load
//   at one per cycle into a CAPACITY-entry buffer; the item with last set
//   starts the burst and raises busy.
//   Burst: first the length is settled, then the key sort on a single
//   byte comparator, one load per pass and one compare per cycle. Decrypt
//   then inverts the order and counts whole rows. Each result first issues
//   the buffer read address, then formats the byte, since the buffer has a
//   single registered read port.
//   Results appear on out_byte / out_last / truncated with valid high for
//   one cycle each; the receiver cannot stall. busy falls as the final
//   result (out_last) is shown, so the next message may start then.
//   A decrypt with less than one whole row gives no results.
//   Reset clears the registers to key 0, key length 1, encrypt, and empties
//   the buffer count; buffer contents are not cleared.
module columnar_transposition_cipher #(
    parameter int CAPACITY = cpt_pkg::CAPACITY_DEF,
    parameter int MAX_KEY  = cpt_pkg::MAX_KEY_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [cpt_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [cpt_pkg::CFG_W-1:0]      wr_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [7:0]                     data_byte,
    input  logic                           last,
    output logic                           valid,
    output logic [7:0]                     out_byte,
    output logic                           out_last,
    output logic                           truncated
);

    import cpt_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(MAX_KEY);
    localparam int KL_W  = $clog2(MAX_KEY + 1);
    localparam int IW    = $clog2(CAPACITY + MAX_KEY);
    localparam int PW    = IDX_W + CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SLOAD,
        S_SCMP,
        S_INV,
        S_ROWS,
        S_ADDR,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [CFG_W-1:0]  key_reg;
    logic [KLEN_W-1:0] klen_reg;
    logic              mode_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [IDX_W-1:0]  order_reg [MAX_KEY];
    logic [IDX_W-1:0]  inv_reg [MAX_KEY];
    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [IDX_W-1:0]  c_reg;
    logic [CNT_W-1:0]  r_reg;
    logic [CNT_W-1:0]  rb_reg;
    logic [CNT_W-1:0]  rows_reg;
    logic              pad_reg;
    logic              lastp_reg;
    logic              valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              trunc_reg;

    logic [KL_W-1:0]   kl;
    logic [IDX_W-1:0]  klm1;
    logic [CNT_W-1:0]  use_tab [MAX_KEY];
    logic [CNT_W-1:0]  usable;
    logic              accept;
    logic              store;
    logic [IDX_W-1:0]  rd_sel;
    logic [IDX_W-1:0]  ord_rd;
    logic [7:0]        key_a;
    logic [7:0]        key_b;
    logic              swap;
    logic [IDX_W-1:0]  cur_n;
    logic [IW-1:0]     rb_plus;
    logic [IW-1:0]     enc_idx;
    logic              enc_pad;
    logic              enc_more;
    logic [PW-1:0]     dec_addr;
    logic [AW-1:0]     raddr;
    logic [7:0]        rdata;

    // Clamp key length into 1..MAX_KEY
    always_comb
    begin
        if (klen_reg == '0)
        begin
            kl = KL_W'(1);
        end
        else if (klen_reg > KLEN_W'(MAX_KEY))
        begin
            kl = KL_W'(MAX_KEY);
        end
        else
        begin
            kl = KL_W'(klen_reg);
        end
    end

    assign klm1 = IDX_W'(kl - KL_W'(1));

    // Usable buffer size: whole rows only
    for (genvar g = 0; g < MAX_KEY; g++)
    begin : g_usable
        localparam int USABLE = (CAPACITY / (g + 1)) * (g + 1);
        assign use_tab[g] = CNT_W'(USABLE);
    end

    assign usable = use_tab[klm1];
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign store  = accept && (cnt_reg < usable);

    // Single read port on the column order
    always_comb
    begin
        case (state_reg)
            S_SLOAD: rd_sel = i_reg;
            S_SCMP:  rd_sel = j_reg;
            default: rd_sel = c_reg;
        endcase
    end

    assign ord_rd = order_reg[rd_sel];

    // Shared byte comparator of the exchange sort
    assign key_a = key_reg[8*cur_reg +: 8];
    assign key_b = key_reg[8*ord_rd +: 8];
    assign swap  = key_a > key_b;
    assign cur_n = swap ? ord_rd : cur_reg;

    assign rb_plus  = IW'(rb_reg) + IW'(kl);
    assign enc_idx  = IW'(rb_reg) + IW'(ord_rd);
    assign enc_pad  = enc_idx >= IW'(n_reg);
    assign enc_more = rb_plus < IW'(n_reg);
    assign dec_addr = PW'(inv_reg[c_reg]) * PW'(rows_reg) + PW'(r_reg);
    assign raddr    = (mode_reg == MODE_DEC) ? dec_addr[AW-1:0] : enc_idx[AW-1:0];

    cpt_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_buf (
        .clk   (clk),
        .we    (store),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (data_byte),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            key_reg      <= '0;
            klen_reg     <= KLEN_W'(1);
            mode_reg     <= MODE_ENC;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            n_reg        <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            cur_reg      <= '0;
            c_reg        <= '0;
            r_reg        <= '0;
            rb_reg       <= '0;
            rows_reg     <= '0;
            pad_reg      <= 1'b0;
            lastp_reg    <= 1'b0;
            valid_reg    <= 1'b0;
            out_byte_reg <= '0;
            out_last_reg <= 1'b0;
            trunc_reg    <= 1'b0;
            for (int x = 0; x < MAX_KEY; x++)
            begin
                order_reg[x] <= '0;
                inv_reg[x]   <= '0;
            end
        end
        else
        begin
            valid_reg <= 1'b0;

            if (wr_en)
            begin
                case (wr_index)
                    REG_KEY_CHARS:  key_reg  <= wr_data;
                    REG_KEY_LENGTH: klen_reg <= wr_data[KLEN_W-1:0];
                    REG_MODE:       mode_reg <= wr_data[0];
                    default:        ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (store)
                        begin
                            cnt_reg <= CNT_W'(cnt_reg + 1'b1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (last)
                        begin
                            state_reg <= S_INIT;
                        end
                    end
                end

                S_INIT:
                begin
                    // Cut back if the key shrank mid-message
                    if (cnt_reg > usable)
                    begin
                        n_reg   <= usable;
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        n_reg <= cnt_reg;
                    end
                    for (int x = 0; x < MAX_KEY; x++)
                    begin
                        order_reg[x] <= IDX_W'(x);
                    end
                    i_reg    <= '0;
                    c_reg    <= '0;
                    r_reg    <= '0;
                    rb_reg   <= '0;
                    rows_reg <= '0;
                    if (kl == KL_W'(1))
                    begin
                        state_reg <= (mode_reg == MODE_DEC) ? S_INV : S_ADDR;
                    end
                    else
                    begin
                        state_reg <= S_SLOAD;
                    end
                end

                S_SLOAD:
                begin
                    cur_reg   <= ord_rd;
                    j_reg     <= IDX_W'(i_reg + 1'b1);
                    state_reg <= S_SCMP;
                end

                S_SCMP:
                begin
                    cur_reg <= cur_n;
                    if (swap)
                    begin
                        order_reg[j_reg] <= cur_reg;
                    end
                    if (j_reg == klm1)
                    begin
                        order_reg[i_reg] <= cur_n;
                        if (i_reg == IDX_W'(klm1 - 1'b1))
                        begin
                            c_reg     <= '0;
                            state_reg <= (mode_reg == MODE_DEC) ? S_INV : S_ADDR;
                        end
                        else
                        begin
                            i_reg     <= IDX_W'(i_reg + 1'b1);
                            state_reg <= S_SLOAD;
                        end
                    end
                    else
                    begin
                        j_reg <= IDX_W'(j_reg + 1'b1);
                    end
                end

                S_INV:
                begin
                    inv_reg[ord_rd] <= c_reg;
                    if (c_reg == klm1)
                    begin
                        c_reg     <= '0;
                        state_reg <= S_ROWS;
                    end
                    else
                    begin
                        c_reg <= IDX_W'(c_reg + 1'b1);
                    end
                end

                S_ROWS:
                begin
                    // Count whole rows by repeated add of the key length
                    if (rb_plus <= IW'(n_reg))
                    begin
                        rb_reg   <= CNT_W'(rb_plus);
                        rows_reg <= CNT_W'(rows_reg + 1'b1);
                    end
                    else if (rows_reg == '0)
                    begin
                        cnt_reg   <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        c_reg     <= '0;
                        r_reg     <= '0;
                        state_reg <= S_ADDR;
                    end
                end

                S_ADDR:
                begin
                    pad_reg <= (mode_reg == MODE_ENC) && enc_pad;
                    if (mode_reg == MODE_DEC)
                    begin
                        lastp_reg <= (c_reg == klm1) &&
                                     (r_reg == CNT_W'(rows_reg - 1'b1));
                        if (c_reg == klm1)
                        begin
                            c_reg <= '0;
                            r_reg <= CNT_W'(r_reg + 1'b1);
                        end
                        else
                        begin
                            c_reg <= IDX_W'(c_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        lastp_reg <= (c_reg == klm1) && !enc_more;
                        if (enc_more)
                        begin
                            rb_reg <= CNT_W'(rb_plus);
                        end
                        else
                        begin
                            rb_reg <= '0;
                            c_reg  <= IDX_W'(c_reg + 1'b1);
                        end
                    end
                    state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    valid_reg    <= 1'b1;
                    out_byte_reg <= pad_reg ? PAD_CHAR : rdata;
                    out_last_reg <= lastp_reg;
                    trunc_reg    <= ovf_reg;
                    if (lastp_reg)
                    begin
                        cnt_reg   <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_ADDR;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign valid     = valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign truncated = trunc_reg;

    `CPT_ASSERT(a_valid_from_out, clk, rst_n, valid |-> $past(state_reg == S_OUT), "result without formatting step")
    `CPT_ASSERT(a_last_frees, clk, rst_n, (valid && out_last) |-> !busy, "busy after final result")
    `CPT_NEVER(a_cnt_range, clk, rst_n, cnt_reg > CNT_W'(CAPACITY), "byte count beyond capacity")
    `CPT_NEVER(a_sort_index, clk, rst_n, (state_reg == S_SCMP) && (j_reg <= i_reg), "sort compares a non-later column")

endmodule
